/* rtl/pel_pkg.sv */
// Package for the preprocessor expression lexer: token and bundle types,
// token kind and error codes, and the character classification helpers.
// Depends on nothing; every rtl file imports it.
package pel_pkg;

    // Default sizing
    localparam int KEYWORD_KEEP_DEF    = 8;
    localparam int MAX_IDENTIFIERS_DEF = 256;
    localparam int TOK_PER_CHAR        = 3;

    // Token kinds
    localparam logic [4:0] K_CONST   = 5'd0;
    localparam logic [4:0] K_DEFINED = 5'd1;
    localparam logic [4:0] K_IDENT   = 5'd2;
    localparam logic [4:0] K_LE      = 5'd3;
    localparam logic [4:0] K_SHL     = 5'd4;
    localparam logic [4:0] K_LT      = 5'd5;
    localparam logic [4:0] K_GE      = 5'd6;
    localparam logic [4:0] K_SHR     = 5'd7;
    localparam logic [4:0] K_GT      = 5'd8;
    localparam logic [4:0] K_EQ      = 5'd9;
    localparam logic [4:0] K_TILDE   = 5'd10;
    localparam logic [4:0] K_NE      = 5'd11;
    localparam logic [4:0] K_NOT     = 5'd12;
    localparam logic [4:0] K_PLUS    = 5'd13;
    localparam logic [4:0] K_MINUS   = 5'd14;
    localparam logic [4:0] K_STAR    = 5'd15;
    localparam logic [4:0] K_SLASH   = 5'd16;
    localparam logic [4:0] K_PERCENT = 5'd17;
    localparam logic [4:0] K_LAND    = 5'd18;
    localparam logic [4:0] K_AMP     = 5'd19;
    localparam logic [4:0] K_LOR     = 5'd20;
    localparam logic [4:0] K_BAR     = 5'd21;
    localparam logic [4:0] K_CARET   = 5'd22;
    localparam logic [4:0] K_LPAREN  = 5'd23;
    localparam logic [4:0] K_RPAREN  = 5'd24;
    localparam logic [4:0] K_QUEST   = 5'd25;
    localparam logic [4:0] K_COLON   = 5'd26;
    localparam logic [4:0] K_END     = 5'd27;
    localparam logic [4:0] K_ERROR   = 5'd28;

    // Error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_STRING    = 3'd1;
    localparam logic [2:0] E_FLOAT     = 3'd2;
    localparam logic [2:0] E_MULTICHAR = 3'd3;
    localparam logic [2:0] E_INVALID   = 3'd4;
    localparam logic [2:0] E_UNEXPECT  = 3'd5;

    // Number bases
    localparam logic [1:0] B_DEC = 2'd0;
    localparam logic [1:0] B_OCT = 2'd1;
    localparam logic [1:0] B_HEX = 2'd2;
    localparam logic [1:0] B_BIN = 2'd3;

    // Keyword classes
    localparam logic [1:0] KW_NONE    = 2'd0;
    localparam logic [1:0] KW_TRUE    = 2'd1;
    localparam logic [1:0] KW_FALSE   = 2'd2;
    localparam logic [1:0] KW_DEFINED = 2'd3;

    typedef enum logic [11:0] {
        M_IDLE     = 12'b0000_0000_0001,
        M_ZERO     = 12'b0000_0000_0010,
        M_NUM      = 12'b0000_0000_0100,
        M_DOT_NUM  = 12'b0000_0000_1000,
        M_DOT_LONE = 12'b0000_0001_0000,
        M_EXP      = 12'b0000_0010_0000,
        M_CH_OPEN  = 12'b0000_0100_0000,
        M_CH_ESC   = 12'b0000_1000_0000,
        M_CH_CLOSE = 12'b0001_0000_0000,
        M_IDENT    = 12'b0010_0000_0000,
        M_OP       = 12'b0100_0000_0000,
        M_SHIFT    = 12'b1000_0000_0000
    } mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [7:0]  idx;
        logic [7:0]  len;
        logic [2:0]  err;
    } tok_t;

    // Tokens caused by one character
    typedef struct packed {
        logic [1:0] cnt;
        tok_t [TOK_PER_CHAR-1:0] toks;
    } bundle_t;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic        has;
        tok_t        tok;
        mode_t       mode;
        logic        acc_ld;
        logic [31:0] acc;
        logic        pend_ld;
        logic        name_ld;
    } beg_t;

    function automatic tok_t mk_tok(logic [4:0] kind, logic [31:0] value,
                                    logic [7:0] idx, logic [7:0] len,
                                    logic [2:0] err);
        tok_t t;
        t.kind  = kind;
        t.value = value;
        t.idx   = idx;
        t.len   = len;
        t.err   = err;
        return t;
    endfunction

    function automatic tok_t err_tok(logic [2:0] code);
        return mk_tok(K_ERROR, 32'd0, 8'd0, 8'd0, code);
    endfunction

    function automatic tok_t kind_tok(logic [4:0] kind);
        return mk_tok(kind, 32'd0, 8'd0, 8'd0, E_NONE);
    endfunction

    function automatic tok_t const_tok(logic [31:0] v);
        return mk_tok(K_CONST, v, 8'd0, 8'd0, E_NONE);
    endfunction

    function automatic logic is_dec(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    // {valid, value} of c as a digit of the given base
    function automatic logic [4:0] digit_val(logic [7:0] c, logic [1:0] base);
        logic [7:0] v;
        logic       ok;
        logic [4:0] radix;
        v  = 8'd0;
        ok = 1'b1;
        if (is_dec(c))
            v = c - 8'h30;
        else if ((c >= "a") && (c <= "f"))
            v = c - 8'h57;
        else if ((c >= "A") && (c <= "F"))
            v = c - 8'h37;
        else
            ok = 1'b0;
        case (base)
            B_DEC:   radix = 5'd10;
            B_OCT:   radix = 5'd8;
            B_HEX:   radix = 5'd16;
            default: radix = 5'd2;
        endcase
        if (v[4:0] >= radix)
            ok = 1'b0;
        return {ok, v[3:0]};
    endfunction

    // Shift-add form of acc times the radix
    function automatic logic [31:0] mul_radix(logic [31:0] a, logic [1:0] base);
        logic [31:0] r;
        case (base)
            B_DEC:   r = (a << 3) + (a << 1);
            B_OCT:   r = a << 3;
            B_HEX:   r = a << 4;
            default: r = a << 1;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] single_op(logic [7:0] p);
        logic [4:0] k;
        case (p)
            "<":     k = K_LT;
            ">":     k = K_GT;
            "!":     k = K_NOT;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "%":     k = K_PERCENT;
            "&":     k = K_AMP;
            "|":     k = K_BAR;
            default: k = K_CARET;
        endcase
        return k;
    endfunction

    // Classify the first seven kept name characters (byte i at [8i+7:8i])
    function automatic logic [1:0] kw_class(logic [55:0] k, logic [7:0] nlen);
        logic [1:0] r;
        r = KW_NONE;
        if (nlen == 8'd4 && k[7:0] == "t" && k[15:8] == "r" && k[23:16] == "u"
            && k[31:24] == "e")
            r = KW_TRUE;
        else if (nlen == 8'd5 && k[7:0] == "f" && k[15:8] == "a" && k[23:16] == "l"
                 && k[31:24] == "s" && k[39:32] == "e")
            r = KW_FALSE;
        else if (nlen == 8'd7 && k[7:0] == "d" && k[15:8] == "e" && k[23:16] == "f"
                 && k[31:24] == "i" && k[39:32] == "n" && k[47:40] == "e"
                 && k[55:48] == "d")
            r = KW_DEFINED;
        return r;
    endfunction

    // Start of a new token at character c
    function automatic beg_t lex_begin(logic [7:0] c);
        beg_t b;
        b      = '0;
        b.mode = M_IDLE;
        case (c) inside
            8'h20, 8'h09, 8'h0A, 8'h0D: b.has = 1'b0;
            8'h22: begin
                b.has = 1'b1;
                b.tok = err_tok(E_STRING);
            end
            "0": begin
                b.mode   = M_ZERO;
                b.acc_ld = 1'b1;
            end
            ["1":"9"]: begin
                b.mode   = M_NUM;
                b.acc_ld = 1'b1;
                b.acc    = {24'd0, c - 8'h30};
            end
            ".":   b.mode = M_DOT_LONE;
            8'h27: b.mode = M_CH_OPEN;
            ["a":"z"], ["A":"Z"], "_": begin
                b.mode    = M_IDENT;
                b.name_ld = 1'b1;
            end
            "<", ">", "=", "!", "+", "-", "*", "/", "%", "&", "|", "^": begin
                b.mode    = M_OP;
                b.pend_ld = 1'b1;
            end
            "~": begin
                b.has = 1'b1;
                b.tok = kind_tok(K_TILDE);
            end
            "(": begin
                b.has = 1'b1;
                b.tok = kind_tok(K_LPAREN);
            end
            ")": begin
                b.has = 1'b1;
                b.tok = kind_tok(K_RPAREN);
            end
            "?": begin
                b.has = 1'b1;
                b.tok = kind_tok(K_QUEST);
            end
            ":": begin
                b.has = 1'b1;
                b.tok = kind_tok(K_COLON);
            end
            default: begin
                b.has = 1'b1;
                b.tok = err_tok(E_UNEXPECT);
            end
        endcase
        return b;
    endfunction

endpackage

/* rtl/pel_front.sv */
// Front end of the lexer: takes one character per transaction, runs the
// scanner state and packs the tokens it causes into one bundle.
// Depends on pel_pkg.
module pel_front
    import pel_pkg::*;
#(
    parameter int KEYWORD_KEEP    = KEYWORD_KEEP_DEF,
    parameter int MAX_IDENTIFIERS = MAX_IDENTIFIERS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_ch,
    input  logic       s_final_char,
    input  logic       s_valid,
    output logic       s_ready,
    input  qstat_t     qstat,
    output logic       push,
    output bundle_t    push_bundle
);

    localparam int KW_AW = $clog2(KEYWORD_KEEP);
    localparam int CW    = $clog2(MAX_IDENTIFIERS + 1);

    mode_t            mode_reg, mode_next;
    logic [31:0]      acc_reg, acc_next;
    logic [1:0]       base_reg, base_next;
    logic [7:0]       pend_reg, pend_next;
    logic [7:0]       nlen_reg, nlen_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             err_reg, err_next;
    logic [7:0]       kw_reg [KEYWORD_KEEP];
    logic             kw_we;
    logic [KW_AW-1:0] kw_addr;
    logic [2:0]       ntok;
    logic             accept;

    function automatic tok_t ident_tok(logic [1:0] cls, logic [7:0] len,
                                       logic [CW-1:0] cnt);
        tok_t t;
        case (cls)
            KW_TRUE:    t = const_tok(32'd1);
            KW_FALSE:   t = const_tok(32'd0);
            KW_DEFINED: t = kind_tok(K_DEFINED);
            default: begin
                if (cnt >= CW'(MAX_IDENTIFIERS))
                    t = err_tok(E_INVALID);
                else
                    t = mk_tok(K_IDENT, 32'd0, 8'(cnt), len, E_NONE);
            end
        endcase
        return t;
    endfunction

    assign s_ready = !qstat.full;
    assign accept  = s_valid && s_ready;

    // Scan one character, then close the expression on the final one
    always_comb begin
        tok_t        tl [5];
        logic [4:0]  dv;
        logic [1:0]  fbase;
        logic [31:0] facc;
        logic        do_num;
        logic        do_begin;
        logic        err_mid;
        beg_t        b;
        logic [7:0]  p;
        logic [7:0]  t;
        logic [55:0] k7_r;
        logic [55:0] k7_v;
        logic [1:0]  cls;
        tok_t        it;

        for (int i = 0; i < 5; i++)
            tl[i] = '0;
        ntok      = 3'd0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        pend_next = pend_reg;
        nlen_next = nlen_reg;
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        kw_we     = 1'b0;
        kw_addr   = '0;
        do_num    = 1'b0;
        do_begin  = 1'b0;
        fbase     = base_reg;
        facc      = acc_reg;
        p         = pend_reg;
        t         = s_ch;
        dv        = '0;
        b         = '0;
        it        = '0;
        for (int i = 0; i < 7; i++) begin
            k7_r[i*8 +: 8] = kw_reg[i];
        end
        cls = kw_class(k7_r, nlen_reg);

        if (!err_reg) begin
            case (mode_reg)
                M_ZERO: begin
                    mode_next = M_NUM;
                    if (s_ch == "x" || s_ch == "X") begin
                        base_next = B_HEX;
                    end else if (s_ch == "b" || s_ch == "B") begin
                        base_next = B_BIN;
                    end else begin
                        fbase     = is_dec(s_ch) ? B_OCT : B_DEC;
                        base_next = fbase;
                        facc      = 32'd0;
                        do_num    = 1'b1;
                    end
                end
                M_NUM: do_num = 1'b1;
                M_DOT_NUM: begin
                    dv = digit_val(s_ch, base_reg);
                    tl[ntok] = err_tok((dv[4] || s_ch == "f") ? E_FLOAT : E_UNEXPECT);
                    ntok = ntok + 3'd1;
                end
                M_DOT_LONE: begin
                    tl[ntok] = err_tok(is_dec(s_ch) ? E_FLOAT : E_UNEXPECT);
                    ntok = ntok + 3'd1;
                end
                M_EXP: begin
                    tl[ntok] = err_tok(E_FLOAT);
                    ntok = ntok + 3'd1;
                end
                M_CH_OPEN: begin
                    if (s_ch == 8'h5C) begin
                        mode_next = M_CH_ESC;
                    end else begin
                        acc_next  = {{24{s_ch[7]}}, s_ch};
                        mode_next = M_CH_CLOSE;
                    end
                end
                M_CH_ESC: begin
                    if (s_ch == "n")
                        t = 8'h0A;
                    else if (s_ch == "r")
                        t = 8'h0D;
                    else if (s_ch == "t")
                        t = 8'h09;
                    acc_next  = {{24{t[7]}}, t};
                    mode_next = M_CH_CLOSE;
                end
                M_CH_CLOSE: begin
                    if (s_ch == 8'h27) begin
                        tl[ntok]  = const_tok(acc_reg);
                        ntok      = ntok + 3'd1;
                        mode_next = M_IDLE;
                    end else begin
                        tl[ntok] = err_tok(E_MULTICHAR);
                        ntok = ntok + 3'd1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(s_ch) || is_dec(s_ch)) begin
                        if (nlen_reg < 8'(KEYWORD_KEEP)) begin
                            kw_we   = 1'b1;
                            kw_addr = nlen_reg[KW_AW-1:0];
                        end
                        if (nlen_reg != 8'hFF)
                            nlen_next = nlen_reg + 8'd1;
                    end else begin
                        it = ident_tok(cls, nlen_reg, cnt_reg);
                        tl[ntok] = it;
                        ntok = ntok + 3'd1;
                        if (it.kind == K_IDENT)
                            cnt_next = cnt_reg + CW'(1);
                        nlen_next = 8'd0;
                        do_begin  = 1'b1;
                    end
                end
                M_OP: begin
                    mode_next = M_IDLE;
                    if (p == "<" || p == ">") begin
                        if (s_ch == "=") begin
                            tl[ntok] = kind_tok((p == "<") ? K_LE : K_GE);
                            ntok = ntok + 3'd1;
                        end else if (s_ch == p) begin
                            mode_next = M_SHIFT;
                        end else begin
                            tl[ntok] = kind_tok(single_op(p));
                            ntok = ntok + 3'd1;
                            do_begin = 1'b1;
                        end
                    end else if (p == "=") begin
                        tl[ntok] = (s_ch == "=") ? kind_tok(K_EQ) : err_tok(E_INVALID);
                        ntok = ntok + 3'd1;
                    end else if (p == "!") begin
                        if (s_ch == "=") begin
                            tl[ntok] = kind_tok(K_NE);
                            ntok = ntok + 3'd1;
                        end else begin
                            tl[ntok] = kind_tok(K_NOT);
                            ntok = ntok + 3'd1;
                            do_begin = 1'b1;
                        end
                    end else if (p == "&" || p == "|") begin
                        if (s_ch == p) begin
                            tl[ntok] = kind_tok((p == "&") ? K_LAND : K_LOR);
                            ntok = ntok + 3'd1;
                        end else if (s_ch == "=") begin
                            tl[ntok] = err_tok(E_INVALID);
                            ntok = ntok + 3'd1;
                        end else begin
                            tl[ntok] = kind_tok(single_op(p));
                            ntok = ntok + 3'd1;
                            do_begin = 1'b1;
                        end
                    end else if (s_ch == "=" || (p == "+" && s_ch == "+")
                                 || (p == "-" && (s_ch == "-" || s_ch == ">"))) begin
                        tl[ntok] = err_tok(E_INVALID);
                        ntok = ntok + 3'd1;
                    end else begin
                        tl[ntok] = kind_tok(single_op(p));
                        ntok = ntok + 3'd1;
                        do_begin = 1'b1;
                    end
                end
                M_SHIFT: begin
                    if (s_ch == "=") begin
                        tl[ntok] = err_tok(E_INVALID);
                        ntok = ntok + 3'd1;
                    end else begin
                        tl[ntok] = kind_tok((p == "<") ? K_SHL : K_SHR);
                        ntok = ntok + 3'd1;
                        do_begin = 1'b1;
                    end
                end
                default: do_begin = 1'b1;
            endcase

            // Accumulate a digit or end the number
            if (do_num) begin
                dv = digit_val(s_ch, fbase);
                if (dv[4]) begin
                    acc_next = mul_radix(facc, fbase) + {28'd0, dv[3:0]};
                end else if (s_ch == "U" || s_ch == "u") begin
                    tl[ntok]  = const_tok(facc);
                    ntok      = ntok + 3'd1;
                    mode_next = M_IDLE;
                end else if (s_ch == ".") begin
                    mode_next = M_DOT_NUM;
                end else if (s_ch == "e" || s_ch == "E") begin
                    mode_next = M_EXP;
                    pend_next = s_ch;
                end else begin
                    tl[ntok] = const_tok(facc);
                    ntok     = ntok + 3'd1;
                    do_begin = 1'b1;
                end
            end

            // Open the next token
            if (do_begin) begin
                b = lex_begin(s_ch);
                mode_next = b.mode;
                if (b.has) begin
                    tl[ntok] = b.tok;
                    ntok = ntok + 3'd1;
                end
                if (b.acc_ld) begin
                    acc_next  = b.acc;
                    base_next = B_DEC;
                end
                if (b.pend_ld)
                    pend_next = s_ch;
                if (b.name_ld) begin
                    nlen_next = 8'd1;
                    kw_we     = 1'b1;
                    kw_addr   = '0;
                end
            end
        end

        err_mid = (ntok != 3'd0 && tl[0].kind == K_ERROR)
                  || (ntok == 3'd2 && tl[1].kind == K_ERROR);
        if (err_mid)
            mode_next = M_IDLE;

        // Name as it stands after this character
        for (int i = 0; i < 7; i++) begin
            k7_v[i*8 +: 8] = (kw_we && kw_addr == KW_AW'(i)) ? s_ch : kw_reg[i];
        end

        // Flush the pending token at the end of the expression
        if (s_final_char && !err_reg && !err_mid) begin
            case (mode_next)
                M_ZERO: begin
                    tl[ntok] = const_tok(32'd0);
                    ntok = ntok + 3'd1;
                end
                M_NUM: begin
                    tl[ntok] = const_tok(acc_next);
                    ntok = ntok + 3'd1;
                end
                M_DOT_NUM: begin
                    tl[ntok] = const_tok(acc_next);
                    ntok = ntok + 3'd1;
                    if (base_next != B_DEC) begin
                        tl[ntok] = err_tok(E_UNEXPECT);
                        ntok = ntok + 3'd1;
                    end
                end
                M_DOT_LONE: begin
                    tl[ntok] = err_tok(E_UNEXPECT);
                    ntok = ntok + 3'd1;
                end
                M_EXP: begin
                    tl[ntok] = const_tok(acc_next);
                    ntok = ntok + 3'd1;
                    tl[ntok] = ident_tok(KW_NONE, 8'd1, cnt_next);
                    ntok = ntok + 3'd1;
                end
                M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: begin
                    tl[ntok] = err_tok(E_MULTICHAR);
                    ntok = ntok + 3'd1;
                end
                M_IDENT: begin
                    tl[ntok] = ident_tok(kw_class(k7_v, nlen_next), nlen_next, cnt_next);
                    ntok = ntok + 3'd1;
                end
                M_OP: begin
                    tl[ntok] = (pend_next == "=") ? err_tok(E_INVALID)
                                                  : kind_tok(single_op(pend_next));
                    ntok = ntok + 3'd1;
                end
                M_SHIFT: begin
                    tl[ntok] = kind_tok((pend_next == "<") ? K_SHL : K_SHR);
                    ntok = ntok + 3'd1;
                end
                default: ntok = ntok;
            endcase
        end

        // Close the expression and return to reset state
        if (s_final_char) begin
            tl[ntok]  = kind_tok(K_END);
            ntok      = ntok + 3'd1;
            mode_next = M_IDLE;
            acc_next  = 32'd0;
            base_next = B_DEC;
            pend_next = 8'd0;
            nlen_next = 8'd0;
            cnt_next  = '0;
            err_next  = 1'b0;
        end else if (err_mid) begin
            err_next = 1'b1;
        end

        for (int i = 0; i < TOK_PER_CHAR; i++)
            push_bundle.toks[i] = tl[i];
        push_bundle.cnt = (ntok > 3'd3) ? 2'd3 : ntok[1:0];
    end

    assign push = accept && (ntok != 3'd0);

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            acc_reg  <= 32'd0;
            base_reg <= B_DEC;
            pend_reg <= 8'd0;
            nlen_reg <= 8'd0;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            base_reg <= base_next;
            pend_reg <= pend_next;
            nlen_reg <= nlen_next;
            cnt_reg  <= cnt_next;
            err_reg  <= err_next;
        end
    end

    // Kept name characters, no reset
    always_ff @(posedge aclk) begin
        if (accept && kw_we)
            kw_reg[kw_addr] <= s_ch;
    end

endmodule

/* rtl/pel_queue.sv */
// Two-entry bundle queue between the lexer front end and the token
// serializer. Depends on pel_pkg.
module pel_queue
    import pel_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_bundle,
    input  logic    pop,
    output qstat_t  qstat,
    output bundle_t head
);

    bundle_t    slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign head        = slot_reg[rptr_reg];

    // Advance pointers
    always_comb begin
        wptr_next  = push ? !wptr_reg : wptr_reg;
        rptr_next  = pop ? !rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Hold bundle payload
    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wptr_reg] <= push_bundle;
    end

endmodule

/* rtl/pel_back.sv */
// Back end of the lexer: walks the head bundle of the queue and presents its
// tokens one per transaction on the result channel. Depends on pel_pkg.
module pel_back
    import pel_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  qstat_t       qstat,
    input  bundle_t      head,
    output logic         pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [4:0]   m_kind,
    output logic [31:0]  m_value,
    output logic [7:0]   m_ident_index,
    output logic [7:0]   m_ident_length,
    output logic [2:0]   m_error_code,
    output logic         m_last_of_run
);

    logic [1:0] idx_reg, idx_next;
    tok_t       cur;
    logic       last;
    logic       take;

    assign m_valid        = !qstat.empty;
    assign cur            = head.toks[idx_reg];
    assign last           = (idx_reg == head.cnt - 2'd1);
    assign take           = m_valid && m_ready;
    assign pop            = take && last;
    assign m_kind         = cur.kind;
    assign m_value        = cur.value;
    assign m_ident_index  = cur.idx;
    assign m_ident_length = cur.len;
    assign m_error_code   = cur.err;
    assign m_last_of_run  = last;

    // Step through the bundle, restart on the next one
    always_comb begin
        if (pop)
            idx_next = 2'd0;
        else if (take)
            idx_next = idx_reg + 2'd1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

/* rtl/preproc_expression_lexer_unit.sv */
// Preprocessor expression lexer, top level: scanner front end, bundle queue
// and token serializer. Depends on pel_pkg, pel_front, pel_queue, pel_back.
//
// Usage: feed the characters of an expression on the s_ channel, one per
// transaction, with s_final_char set on the last one. Tokens leave on the m_
// channel, one per transaction; m_last_of_run marks the last token caused by
// a character. Each expression ends with an END token (unless three tokens
// before it already fill that character's slots).
// A token's bundle is registered in the queue before it is offered.
// Throughput: one character per cycle while each causes at most one token;
// a character causing n tokens holds the result side until all n are taken, and the
// two-entry queue absorbs that so the input keeps flowing until it fills.
// When the receiver stalls, results wait in the queue and s_ready drops
// once both entries are taken. Synchronous reset clears the scanner state
// and empties the queue; kept name characters are not cleared.
module preproc_expression_lexer_unit
    import pel_pkg::*;
#(
    parameter int KEYWORD_KEEP    = KEYWORD_KEEP_DEF,
    parameter int MAX_IDENTIFIERS = MAX_IDENTIFIERS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_ch,
    input  logic               s_final_char,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_kind,
    output logic signed [31:0] m_value,
    output logic [7:0]         m_ident_index,
    output logic [7:0]         m_ident_length,
    output logic [2:0]         m_error_code,
    output logic               m_last_of_run
);

    qstat_t  qstat;
    logic    push;
    logic    pop;
    bundle_t push_bundle;
    bundle_t head;

    pel_front #(
        .KEYWORD_KEEP    (KEYWORD_KEEP),
        .MAX_IDENTIFIERS (MAX_IDENTIFIERS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_ch         (s_ch),
        .s_final_char (s_final_char),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .qstat        (qstat),
        .push         (push),
        .push_bundle  (push_bundle)
    );

    pel_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .qstat       (qstat),
        .head        (head)
    );

    pel_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .qstat          (qstat),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_value        (m_value),
        .m_ident_index  (m_ident_index),
        .m_ident_length (m_ident_length),
        .m_error_code   (m_error_code),
        .m_last_of_run  (m_last_of_run)
    );

    // An end token always closes its character's run
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == K_END) |-> m_last_of_run)
        else $error("end token not last of run");

    // Error code present exactly on error tokens
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kind == K_ERROR) == (m_error_code != E_NONE)))
        else $error("error code mismatch");

    // Only constants carry a value
    a_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != K_CONST) |-> (m_value == 32'sd0))
        else $error("value on non-constant token");

    // Input is refused only when the queue is full
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_ready) |-> qstat.full)
        else $error("input stalled with room in queue");

endmodule

/* dv/tb_preproc_expression_lexer_unit.sv */
// Self-checking testbench for preproc_expression_lexer_unit: expressions and noise in,
// tokens checked against a local scanner model, a first quarter without idling, then three idling phases.
// Depends on pel_pkg and the lexer RTL.
module tb_preproc_expression_lexer_unit;
    import pel_pkg::*;

    typedef struct {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [7:0]  idx;
        logic [7:0]  len;
        logic [2:0]  err;
        logic        last;
    } token_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } char_item_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic [7:0]         s_ch = 8'd0;
    logic               s_final_char = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [4:0]         m_kind;
    logic signed [31:0] m_value;
    logic [7:0]         m_ident_index;
    logic [7:0]         m_ident_length;
    logic [2:0]         m_error_code;
    logic               m_last_of_run;

    preproc_expression_lexer_unit u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Scanner model state
    mode_t       lmode;
    logic [31:0] acc;
    logic [1:0]  nbase;
    logic [7:0]  pend;
    logic [7:0]  kw_keep [8];
    int          nlen;
    int          ident_cnt;
    bit          err_seen;

    token_t      step_toks[$];
    token_t      expected_toks[$];
    char_item_t  pending_chars[$];
    logic [7:0]  expr_buf[$];

    int errors = 0;
    int tokens_checked = 0;
    int chars_taken = 0;
    int chars_total = 0;
    int exprs_sent = 0;
    bit stim_ready = 1'b0;

    function automatic int radix_of(logic [1:0] b);
        case (b)
            B_DEC: return 10;
            B_OCT: return 8;
            B_HEX: return 16;
            default: return 2;
        endcase
    endfunction

    function automatic int digit_of(logic [7:0] c, logic [1:0] b);
        int v;
        v = -1;
        if (c >= "0" && c <= "9") v = int'(c - 8'h30);
        else if (c >= "a" && c <= "f") v = int'(c - 8'h57);
        else if (c >= "A" && c <= "F") v = int'(c - 8'h37);
        if (v < 0 || v >= radix_of(b)) return -1;
        return v;
    endfunction

    function automatic bit alpha_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit alnum_c(logic [7:0] c);
        return alpha_c(c) || (c >= "0" && c <= "9");
    endfunction

    // Queue one token of the current character, at most three; an error silences all but the end token
    function automatic void push_tok(logic [4:0] k, logic [31:0] v, logic [7:0] i,
                                     logic [7:0] l, logic [2:0] e);
        token_t t;
        if (err_seen && k != K_END) return;
        if (step_toks.size() >= 3) return;
        t = '{k, v, i, l, e, 1'b0};
        step_toks.insert(step_toks.size(), t);
        if (k == K_ERROR) begin
            err_seen = 1'b1;
            lmode = M_IDLE;
        end
    endfunction

    function automatic void push_err(logic [2:0] e);
        push_tok(K_ERROR, 32'd0, 8'd0, 8'd0, e);
    endfunction

    function automatic void push_kind(logic [4:0] k);
        push_tok(k, 32'd0, 8'd0, 8'd0, E_NONE);
    endfunction

    function automatic void name_put(logic [7:0] c);
        if (nlen < 8) kw_keep[nlen] = c;
        if (nlen < 255) nlen++;
    endfunction

    function automatic bit name_is(string s);
        if (nlen != s.len()) return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (kw_keep[i] != s[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void name_done();
        if (name_is("true")) push_tok(K_CONST, 32'd1, 8'd0, 8'd0, E_NONE);
        else if (name_is("false")) push_tok(K_CONST, 32'd0, 8'd0, 8'd0, E_NONE);
        else if (name_is("defined")) push_kind(K_DEFINED);
        else if (ident_cnt >= 256) push_err(E_INVALID);
        else begin
            push_tok(K_IDENT, 32'd0, ident_cnt[7:0], nlen[7:0], E_NONE);
            ident_cnt++;
        end
        nlen = 0;
    endfunction

    function automatic logic [4:0] single_kind(logic [7:0] p);
        case (p)
            "<": return K_LT;
            ">": return K_GT;
            "!": return K_NOT;
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            "/": return K_SLASH;
            "%": return K_PERCENT;
            "&": return K_AMP;
            "|": return K_BAR;
            default: return K_CARET;
        endcase
    endfunction

    function automatic void clear_state();
        lmode = M_IDLE;
        acc = 32'd0;
        nbase = B_DEC;
        pend = 8'd0;
        nlen = 0;
        ident_cnt = 0;
        err_seen = 1'b0;
    endfunction

    // Open a new token at character c
    function automatic void lex_start(logic [7:0] c);
        lmode = M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D) return;
        if (c == 8'h22) begin
            push_err(E_STRING);
        end else if (c == "0") begin
            lmode = M_ZERO; acc = 32'd0; nbase = B_DEC;
        end else if (c >= "1" && c <= "9") begin
            lmode = M_NUM; acc = {24'd0, c - 8'h30}; nbase = B_DEC;
        end else if (c == ".") begin
            lmode = M_DOT_LONE;
        end else if (c == 8'h27) begin
            lmode = M_CH_OPEN;
        end else if (alpha_c(c)) begin
            lmode = M_IDENT; nlen = 0; name_put(c);
        end else begin
            case (c)
                "<", ">", "=", "!", "+", "-", "*", "/", "%", "&", "|", "^": begin
                    lmode = M_OP; pend = c;
                end
                "~": push_kind(K_TILDE);
                "(": push_kind(K_LPAREN);
                ")": push_kind(K_RPAREN);
                "?": push_kind(K_QUEST);
                ":": push_kind(K_COLON);
                default: push_err(E_UNEXPECT);
            endcase
        end
    endfunction

    function automatic void num_char(logic [7:0] t);
        int d;
        d = digit_of(t, nbase);
        if (d >= 0) begin
            acc = acc * radix_of(nbase) + d;
        end else if (t == "U" || t == "u") begin
            push_tok(K_CONST, acc, 8'd0, 8'd0, E_NONE); lmode = M_IDLE;
        end else if (t == ".") begin
            lmode = M_DOT_NUM;
        end else if (t == "e" || t == "E") begin
            lmode = M_EXP; pend = t;
        end else begin
            push_tok(K_CONST, acc, 8'd0, 8'd0, E_NONE); lex_start(t);
        end
    endfunction

    function automatic void op_char(logic [7:0] t);
        logic [7:0] p;
        p = pend;
        lmode = M_IDLE;
        if (p == "<" || p == ">") begin
            if (t == "=") push_kind(p == "<" ? K_LE : K_GE);
            else if (t == p) lmode = M_SHIFT;
            else begin push_kind(single_kind(p)); lex_start(t); end
        end else if (p == "=") begin
            if (t == "=") push_kind(K_EQ); else push_err(E_INVALID);
        end else if (p == "!") begin
            if (t == "=") push_kind(K_NE);
            else begin push_kind(K_NOT); lex_start(t); end
        end else if (p == "&" || p == "|") begin
            if (t == p) push_kind(p == "&" ? K_LAND : K_LOR);
            else if (t == "=") push_err(E_INVALID);
            else begin push_kind(single_kind(p)); lex_start(t); end
        end else if (t == "=" || (p == "+" && t == "+") ||
                     (p == "-" && (t == "-" || t == ">"))) begin
            push_err(E_INVALID);
        end else begin
            push_kind(single_kind(p)); lex_start(t);
        end
    endfunction

    function automatic void lex_char(logic [7:0] t);
        logic [7:0] e;
        case (lmode)
            M_ZERO: begin
                lmode = M_NUM;
                if (t == "x" || t == "X") nbase = B_HEX;
                else if (t == "b" || t == "B") nbase = B_BIN;
                else begin
                    nbase = (t >= "0" && t <= "9") ? B_OCT : B_DEC;
                    num_char(t);
                end
            end
            M_NUM: num_char(t);
            M_DOT_NUM: push_err((digit_of(t, nbase) >= 0 || t == "f") ? E_FLOAT : E_UNEXPECT);
            M_DOT_LONE: push_err((t >= "0" && t <= "9") ? E_FLOAT : E_UNEXPECT);
            M_EXP: push_err(E_FLOAT);
            M_CH_OPEN, M_CH_ESC: begin
                e = t;
                if (lmode == M_CH_OPEN && t == "\\") begin
                    lmode = M_CH_ESC;
                end else begin
                    if (lmode == M_CH_ESC) begin
                        if (t == "n") e = 8'h0A;
                        else if (t == "r") e = 8'h0D;
                        else if (t == "t") e = 8'h09;
                    end
                    acc = {{24{e[7]}}, e};
                    lmode = M_CH_CLOSE;
                end
            end
            M_CH_CLOSE: begin
                if (t == 8'h27) begin
                    push_tok(K_CONST, acc, 8'd0, 8'd0, E_NONE); lmode = M_IDLE;
                end else push_err(E_MULTICHAR);
            end
            M_IDENT: begin
                if (alnum_c(t)) name_put(t);
                else begin name_done(); lex_start(t); end
            end
            M_OP: op_char(t);
            M_SHIFT: begin
                if (t == "=") push_err(E_INVALID);
                else begin push_kind(pend == "<" ? K_SHL : K_SHR); lex_start(t); end
            end
            default: lex_start(t);
        endcase
    endfunction

    // Settle whatever token is still open at the end of the expression
    function automatic void lex_flush();
        case (lmode)
            M_ZERO: push_tok(K_CONST, 32'd0, 8'd0, 8'd0, E_NONE);
            M_NUM: push_tok(K_CONST, acc, 8'd0, 8'd0, E_NONE);
            M_DOT_NUM: begin
                push_tok(K_CONST, acc, 8'd0, 8'd0, E_NONE);
                if (nbase != B_DEC) push_err(E_UNEXPECT);
            end
            M_DOT_LONE: push_err(E_UNEXPECT);
            M_EXP: begin
                push_tok(K_CONST, acc, 8'd0, 8'd0, E_NONE);
                nlen = 0; name_put(pend); name_done();
            end
            M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: push_err(E_MULTICHAR);
            M_IDENT: name_done();
            M_OP: begin
                if (pend == "=") push_err(E_INVALID);
                else push_kind(single_kind(pend));
            end
            M_SHIFT: push_kind(pend == "<" ? K_SHL : K_SHR);
            default: ;
        endcase
        lmode = M_IDLE;
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic fin);
        step_toks.delete();
        if (!err_seen) lex_char(c);
        if (fin) begin
            if (!err_seen) lex_flush();
            push_kind(K_END);
            clear_state();
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) expected_toks.insert(expected_toks.size(), step_toks[i]);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at token %0d: %s got %0d expected %0d",
                 tokens_checked, what, got, want);
        errors++;
    endtask

    // Stimulus builders
    function automatic void put_ch(logic [7:0] c);
        expr_buf.insert(expr_buf.size(), c);
    endfunction

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) put_ch(s[i]);
    endtask

    task automatic close_expr();
        char_item_t it;
        foreach (expr_buf[i]) begin
            it.ch = expr_buf[i];
            it.fin = (i == expr_buf.size() - 1);
            pending_chars.insert(pending_chars.size(), it);
        end
        expr_buf.delete();
        exprs_sent++;
    endtask

    task automatic add_expr(string s);
        put_str(s);
        close_expr();
    endtask

    task automatic put_digits(logic [1:0] b, int n);
        string hexd;
        hexd = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++) begin
            case (b)
                B_DEC: put_ch(hexd[$urandom_range(0, 9)]);
                B_OCT: put_ch(hexd[$urandom_range(0, 7)]);
                B_HEX: put_ch(hexd[$urandom_range(0, 21)]);
                default: put_ch(hexd[$urandom_range(0, 1)]);
            endcase
        end
    endtask

    // Append one random token-ish fragment, mostly well formed
    task automatic add_frag();
        string ops[$];
        string idc;
        int n;
        ops = '{"<=", "<<", "<", ">=", ">>", ">", "==", "~", "!=", "!", "+", "-", "*",
                "/", "%", "&&", "&", "||", "|", "^", "(", ")", "?", ":",
                "=", "+=", "++", "--", "->", "<<=", ">>=", "&=", "|=", "^="};
        idc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        case ($urandom_range(0, 15))
            0, 1: put_digits(B_DEC, $urandom_range(1, 12));
            2: begin put_str("0x"); put_digits(B_HEX, $urandom_range(1, 10)); end
            3: begin put_str("0B"); put_digits(B_BIN, $urandom_range(1, 34)); end
            4: begin put_str("0"); put_digits(B_OCT, $urandom_range(0, 12)); end
            5, 6, 7: put_str(ops[$urandom_range(0, ops.size() - 1)]);
            8, 9: begin
                n = $urandom_range(1, 10);
                put_ch(idc[$urandom_range(0, 52)]);
                for (int i = 1; i < n; i++) put_ch(idc[$urandom_range(0, 62)]);
            end
            10: case ($urandom_range(0, 3))
                0: put_str("true");
                1: put_str("false");
                2: put_str("defined");
                default: put_str("definee");
            endcase
            11: begin
                put_ch(8'h27);
                if ($urandom_range(0, 2) == 0) put_ch("\\");
                put_ch(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 5) != 0) put_ch(8'h27);
            end
            12: case ($urandom_range(0, 5))
                0: put_str("1.5");
                1: put_str(".5");
                2: put_str("0x1.f");
                3: put_str("3e");
                4: put_str("7E2");
                default: put_str(".");
            endcase
            13: if ($urandom_range(0, 1)) put_str("u"); else put_str("U");
            14: put_ch(8'($urandom_range(0, 255)));
            default: put_str("\t");
        endcase
        if ($urandom_range(0, 2) == 0) put_str(" ");
    endtask

    // Input driver: hold the payload until the transaction completes
    always @(posedge aclk) begin
        int pct;
        pct = 0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (chars_total > 0) begin
                case (chars_taken * 4 / chars_total)
                    1: pct = 78;
                    3: pct = 32;
                    default: pct = 0;
                endcase
            end
            if (stim_ready && pending_chars.size() > 0 && $urandom_range(0, 99) >= pct) begin
                s_ch <= pending_chars[0].ch;
                s_final_char <= pending_chars[0].fin;
                s_valid <= 1'b1;
                void'(pending_chars.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        int pct;
        pct = 0;
        if (chars_total > 0) begin
            case (chars_taken * 4 / chars_total)
                2: pct = 78;
                3: pct = 32;
                default: pct = 0;
            endcase
        end
        m_ready <= aresetn && ($urandom_range(0, 99) >= pct);
    end

    // Monitor: predict on accepted characters, check accepted tokens
    always @(posedge aclk) begin
        token_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_tokens(s_ch, s_final_char);
                chars_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_toks.size() == 0) begin
                    report_mismatch("unexpected token kind", m_kind, -1);
                end else begin
                    want = expected_toks.pop_front();
                    if (m_kind !== want.kind) report_mismatch("kind", m_kind, want.kind);
                    if (m_value !== want.value)
                        report_mismatch("value", m_value, $signed(want.value));
                    if (m_ident_index !== want.idx)
                        report_mismatch("ident_index", m_ident_index, want.idx);
                    if (m_ident_length !== want.len)
                        report_mismatch("ident_length", m_ident_length, want.len);
                    if (m_error_code !== want.err)
                        report_mismatch("error_code", m_error_code, want.err);
                    if (m_last_of_run !== want.last)
                        report_mismatch("last_of_run", m_last_of_run, want.last);
                end
                tokens_checked++;
            end
        end
    end

    initial begin
        clear_state();
        // Directed: number bases and wrap, escapes, keywords, lookahead cases
        add_expr("0xFFFFFFFFF+0b1u");
        add_expr("'\\n'<<=");
        add_expr("defined true");
        add_expr("1.");
        add_expr("0x1.");
        add_expr("9e");
        add_expr("\"");
        add_expr("'ab'");
        // Names near the keywords and longer than the kept characters
        add_expr("definedx true_");
        add_expr("abcdefghijk");
        // Random expressions with some bare noise characters
        while (pending_chars.size() < 300) begin
            if ($urandom_range(0, 9) == 0) begin
                put_ch(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) close_expr();
            end else begin
                repeat ($urandom_range(1, 6)) add_frag();
                close_expr();
            end
        end
        chars_total = pending_chars.size();
        stim_ready = 1'b1;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_chars.size() > 0 || s_valid) @(posedge aclk);
        while (expected_toks.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d characters in %0d expressions sent, %0d tokens checked",
                 chars_taken, exprs_sent, tokens_checked);
        if (errors == 0 && expected_toks.size() == 0)
            $display("PASS preproc_expression_lexer_unit");
        else
            $display("FAIL preproc_expression_lexer_unit");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL preproc_expression_lexer_unit");
        $finish;
    end

endmodule
